// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the reduction schedule generator modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge out of reset.
`define RSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RSG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reduction schedule generator package
// Shared constants, microcode word layout, control program and the control
// and status bundles passed between sequencer and datapath.
// ----------------------------------------------------------------------------
package rsg_pkg;

	localparam int RSG_MAX_NODES   = 32;
	localparam int RSG_MAX_ACTIONS = 64;
	localparam int RESULT_CAP      = 63;

	localparam int NODE_W     = 5;
	localparam int COUNT_W    = 6;
	localparam int PAT_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

	localparam logic [PAT_W-1:0] PAT_STAR = 2'd0;
	localparam logic [PAT_W-1:0] PAT_ALL  = 2'd1;
	localparam logic [PAT_W-1:0] PAT_BFLY = 2'd2;

	localparam logic [PAT_W-1:0]   PATTERN_RST    = PAT_BFLY;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 6'd32;
	localparam logic [NODE_W-1:0]  HUB_NODE       = 5'd0;

	typedef enum logic [2:0] {
		PS_SELF,
		PS_HUB,
		PS_J,
		PS_I_MINUS_M,
		PS_I_PLUS_M,
		PS_PARTNER
	} peer_sel_t;

	typedef enum logic [2:0] {
		G_NEVER,
		G_ALWAYS,
		G_GOOD,
		G_J_NOT_HUB,
		G_J_NOT_SELF,
		G_HAS_OUT,
		G_K_ACTIVE
	} guard_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_GOTO,
		JC_JLOOP,
		JC_KEXIT,
		JC_KNEXT,
		JC_DISPATCH,
		JC_END
	} jcond_t;

	typedef logic [3:0] uc_addr_t;

	localparam uc_addr_t UA_START     = 4'd0;
	localparam uc_addr_t UA_BAD       = 4'd1;
	localparam uc_addr_t UA_STAR_LEAF = 4'd2;
	localparam uc_addr_t UA_STAR_LRX  = 4'd3;
	localparam uc_addr_t UA_STAR_HUB  = 4'd4;
	localparam uc_addr_t UA_STAR_HTX  = 4'd5;
	localparam uc_addr_t UA_A2A_TX    = 4'd6;
	localparam uc_addr_t UA_A2A_RX    = 4'd7;
	localparam uc_addr_t UA_BF_OUT    = 4'd8;
	localparam uc_addr_t UA_BF_ORX    = 4'd9;
	localparam uc_addr_t UA_BF_IN     = 4'd10;
	localparam uc_addr_t UA_BF_KTX    = 4'd11;
	localparam uc_addr_t UA_BF_KRX    = 4'd12;
	localparam uc_addr_t UA_BF_ITX    = 4'd13;
	localparam uc_addr_t UA_END       = 4'd14;

	typedef struct packed {
		guard_t    guard;
		peer_sel_t peer;
		logic      recv;
		logic      js;
		logic      red;
		logic      bad;
		jcond_t    jc;
		uc_addr_t  target;
	} uc_word_t;

	typedef struct packed {
		logic      emit;
		peer_sel_t peer;
		logic      recv;
		logic      js;
		logic      red;
		logic      bad;
		logic      j_inc;
		logic      j_clr;
		logic      k_shift;
		logic      finish;
	} rsg_ctrl_t;

	typedef struct packed {
		logic             bad;
		logic [PAT_W-1:0] pattern;
		logic             i_hub;
		logic             outlier;
		logic             has_out;
		logic             j_more;
		logic             j_not_hub;
		logic             j_not_self;
		logic             k_active;
		logic             at_limit;
		logic             pend_valid;
		logic             stall;
	} rsg_stat_t;

	function automatic uc_word_t uc_rom(input uc_addr_t a);
		uc_word_t w;
		unique case (a)
			UA_START:     w = '{G_GOOD, PS_SELF, 1'b1, 1'b0, 1'b1, 1'b0, JC_DISPATCH, UA_START};
			UA_BAD:       w = '{G_ALWAYS, PS_HUB, 1'b0, 1'b0, 1'b0, 1'b1, JC_GOTO, UA_END};
			UA_STAR_LEAF: w = '{G_ALWAYS, PS_HUB, 1'b0, 1'b0, 1'b0, 1'b0, JC_NEXT, UA_END};
			UA_STAR_LRX:  w = '{G_ALWAYS, PS_HUB, 1'b1, 1'b0, 1'b0, 1'b0, JC_GOTO, UA_END};
			UA_STAR_HUB:  w = '{G_J_NOT_HUB, PS_J, 1'b1, 1'b0, 1'b1, 1'b0, JC_JLOOP, UA_STAR_HTX};
			UA_STAR_HTX:  w = '{G_J_NOT_HUB, PS_J, 1'b0, 1'b0, 1'b0, 1'b0, JC_JLOOP, UA_END};
			UA_A2A_TX:    w = '{G_J_NOT_SELF, PS_J, 1'b0, 1'b0, 1'b0, 1'b0, JC_JLOOP, UA_A2A_RX};
			UA_A2A_RX:    w = '{G_J_NOT_SELF, PS_J, 1'b1, 1'b0, 1'b1, 1'b0, JC_JLOOP, UA_END};
			UA_BF_OUT:    w = '{G_ALWAYS, PS_I_MINUS_M, 1'b0, 1'b0, 1'b0, 1'b0, JC_NEXT, UA_END};
			UA_BF_ORX:    w = '{G_ALWAYS, PS_I_MINUS_M, 1'b1, 1'b0, 1'b0, 1'b0, JC_GOTO, UA_END};
			UA_BF_IN:     w = '{G_HAS_OUT, PS_I_PLUS_M, 1'b1, 1'b1, 1'b1, 1'b0, JC_NEXT, UA_END};
			UA_BF_KTX:    w = '{G_K_ACTIVE, PS_PARTNER, 1'b0, 1'b0, 1'b0, 1'b0, JC_KEXIT, UA_BF_ITX};
			UA_BF_KRX:    w = '{G_ALWAYS, PS_PARTNER, 1'b1, 1'b1, 1'b1, 1'b0, JC_KNEXT, UA_BF_KTX};
			UA_BF_ITX:    w = '{G_HAS_OUT, PS_I_PLUS_M, 1'b0, 1'b0, 1'b0, 1'b0, JC_GOTO, UA_END};
			UA_END:       w = '{G_NEVER, PS_HUB, 1'b0, 1'b0, 1'b0, 1'b0, JC_END, UA_END};
			default:      w = '{G_NEVER, PS_HUB, 1'b0, 1'b0, 1'b0, 1'b0, JC_END, UA_END};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/rsg_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one node number per request under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsg_req_if;
	import rsg_pkg::*;

	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node_id;

	modport source (output valid, output node_id, input ready);
	modport sink (input valid, input node_id, output ready);
endinterface

// ----- rtl/rsg_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Action channel
// Carries one reduction action per transfer under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsg_rsp_if;
	import rsg_pkg::*;

	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] peer_id;
	logic              receive;
	logic              jumpstart;
	logic              reduce;
	logic              bad_request;
	logic              last;

	modport source (
		output valid, output peer_id, output receive, output jumpstart,
		output reduce, output bad_request, output last, input ready
	);
	modport sink (
		input valid, input peer_id, input receive, input jumpstart,
		input reduce, input bad_request, input last, output ready
	);
endinterface

// ----- rtl/rsg_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reduction schedule microsequencer
// Steps through the control program, evaluates guards and jumps, and drives
// the datapath with one control bundle per cycle, holding the bundle while the datapath stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsg_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rsg_pkg::rsg_stat_t stat,
	output rsg_pkg::rsg_ctrl_t ctrl,
	output logic              busy
);
	import rsg_pkg::*;

	uc_addr_t pc_q;
	logic     busy_q;
	uc_word_t uw;
	logic     guard_ok;
	logic     emit;
	uc_addr_t disp_target;
	uc_addr_t pc_next;

	always_comb begin
		uw = uc_rom(pc_q);
	end

	always_comb begin
		unique case (uw.guard)
			G_NEVER:      guard_ok = 1'b0;
			G_ALWAYS:     guard_ok = 1'b1;
			G_GOOD:       guard_ok = !stat.bad;
			G_J_NOT_HUB:  guard_ok = stat.j_not_hub;
			G_J_NOT_SELF: guard_ok = stat.j_not_self;
			G_HAS_OUT:    guard_ok = stat.has_out;
			G_K_ACTIVE:   guard_ok = stat.k_active;
			default:      guard_ok = 1'b0;
		endcase
		emit = busy_q && guard_ok;
	end

	always_comb begin
		priority if (stat.bad) begin
			disp_target = UA_BAD;
		end else begin
			unique case (stat.pattern)
				PAT_STAR: disp_target = stat.i_hub ? UA_STAR_HUB : UA_STAR_LEAF;
				PAT_ALL:  disp_target = UA_A2A_TX;
				PAT_BFLY: disp_target = stat.outlier ? UA_BF_OUT : UA_BF_IN;
				default:  disp_target = UA_BAD;
			endcase
		end
	end

	always_comb begin
		priority if (emit && stat.at_limit) begin
			pc_next = UA_END;
		end else begin
			unique case (uw.jc)
				JC_NEXT:     pc_next = uc_addr_t'(pc_q + 1'b1);
				JC_GOTO:     pc_next = uw.target;
				JC_JLOOP:    pc_next = stat.j_more ? pc_q : uw.target;
				JC_KEXIT:    pc_next = stat.k_active ? uc_addr_t'(pc_q + 1'b1) : uw.target;
				JC_KNEXT:    pc_next = uw.target;
				JC_DISPATCH: pc_next = disp_target;
				JC_END:      pc_next = UA_END;
				default:     pc_next = UA_END;
			endcase
		end
	end

	always_comb begin
		ctrl.emit    = emit;
		ctrl.peer    = uw.peer;
		ctrl.recv    = uw.recv;
		ctrl.js      = uw.js;
		ctrl.red     = uw.red;
		ctrl.bad     = uw.bad;
		ctrl.j_inc   = busy_q && (uw.jc == JC_JLOOP) && stat.j_more;
		ctrl.j_clr   = busy_q && (uw.jc == JC_JLOOP) && !stat.j_more;
		ctrl.k_shift = busy_q && (uw.jc == JC_KNEXT);
		ctrl.finish  = busy_q && (uw.jc == JC_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= UA_START;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= UA_START;
		end else if (busy_q && !stat.stall) begin
			pc_q <= pc_next;
			if (uw.jc == JC_END) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	`RSG_ASSERT_IMP(a_finish_has_pending, ctrl.finish, stat.pend_valid, "list ends with no held action")
	`RSG_ASSERT_NEXT(a_finish_releases, ctrl.finish && !stat.stall, !busy_q, "sequencer stays busy after list end")
	`RSG_ASSERT_IMP(a_idle_quiet, !busy_q, !ctrl.emit && !ctrl.finish, "control active while idle")

endmodule

// ----- rtl/rsg_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reduction schedule datapath
// Holds the configuration, the request context and loop counters, forms each
// action, and keeps one action in hand so the final one can be marked last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsg_dpath #(
	parameter int MAX_NODES   = rsg_pkg::RSG_MAX_NODES,
	parameter int MAX_ACTIONS = rsg_pkg::RSG_MAX_ACTIONS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             start,
	input  logic [rsg_pkg::NODE_W-1:0]       node_id,
	input  rsg_pkg::rsg_ctrl_t               ctrl,
	output rsg_pkg::rsg_stat_t               stat,
	rsg_rsp_if.source                        rsp
);
	import rsg_pkg::*;

	localparam int LIMIT = (MAX_ACTIONS < RESULT_CAP) ? MAX_ACTIONS : RESULT_CAP;
	localparam int CNT_W = $clog2(LIMIT + 1);
	localparam logic [COUNT_W-1:0] NODE_CAP = COUNT_W'(MAX_NODES);

	logic [PAT_W-1:0]   pattern_q;
	logic [COUNT_W-1:0] count_q;

	logic [NODE_W-1:0]  i_q;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] m_q;
	logic               bad_q;
	logic [NODE_W-1:0]  j_q;
	logic [COUNT_W-1:0] kbit_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               pend_v_q;
	logic [NODE_W-1:0]  pend_peer_q;
	logic               pend_recv_q;
	logic               pend_js_q;
	logic               pend_red_q;
	logic               pend_bad_q;

	logic               out_v_q;
	logic [NODE_W-1:0]  out_peer_q;
	logic               out_recv_q;
	logic               out_js_q;
	logic               out_red_q;
	logic               out_bad_q;
	logic               out_last_q;

	logic [COUNT_W-1:0] n_sat;
	logic [COUNT_W-1:0] m_new;
	logic               bad_new;
	logic [NODE_W-1:0]  cand_peer;
	logic               push;
	logic               stall;

	always_comb begin
		n_sat = (count_q > NODE_CAP) ? NODE_CAP : count_q;
		m_new = '0;
		for (int b = 0; b < COUNT_W; b++) begin
			if (n_sat[b]) begin
				m_new = COUNT_W'(1) << b;
			end
		end
		bad_new = ({1'b0, node_id} >= n_sat) || (pattern_q > PAT_BFLY);
	end

	always_comb begin
		unique case (ctrl.peer)
			PS_SELF:      cand_peer = i_q;
			PS_HUB:       cand_peer = HUB_NODE;
			PS_J:         cand_peer = j_q;
			PS_I_MINUS_M: cand_peer = i_q - m_q[NODE_W-1:0];
			PS_I_PLUS_M:  cand_peer = i_q + m_q[NODE_W-1:0];
			PS_PARTNER:   cand_peer = i_q ^ kbit_q[NODE_W-1:0];
			default:      cand_peer = HUB_NODE;
		endcase
	end

	assign push  = (ctrl.emit && pend_v_q) || ctrl.finish;
	assign stall = push && out_v_q && !rsp.ready;

	always_comb begin
		stat.bad        = bad_q;
		stat.pattern    = pattern_q;
		stat.i_hub      = (i_q == HUB_NODE);
		stat.outlier    = ({1'b0, i_q} >= m_q);
		stat.has_out    = (({2'b00, i_q} + {1'b0, m_q}) < {1'b0, n_q});
		stat.j_more     = (({1'b0, j_q} + 1'b1) < n_q);
		stat.j_not_hub  = (j_q != HUB_NODE);
		stat.j_not_self = (j_q != i_q);
		stat.k_active   = (kbit_q < m_q);
		stat.at_limit   = (cnt_q == CNT_W'(LIMIT - 1));
		stat.pend_valid = pend_v_q;
		stat.stall      = stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RST;
			count_q   <= NODE_COUNT_RST;
			j_q       <= '0;
			kbit_q    <= COUNT_W'(1);
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_PATTERN) begin
					pattern_q <= cfg_data[PAT_W-1:0];
				end
				if (cfg_index == CFG_NODE_COUNT) begin
					count_q <= cfg_data[COUNT_W-1:0];
				end
			end
			if (start) begin
				j_q      <= '0;
				kbit_q   <= COUNT_W'(1);
				cnt_q    <= '0;
				pend_v_q <= 1'b0;
			end else if (!stall) begin
				if (ctrl.j_inc) begin
					j_q <= j_q + 1'b1;
				end else if (ctrl.j_clr) begin
					j_q <= '0;
				end
				if (ctrl.k_shift) begin
					kbit_q <= kbit_q << 1;
				end
				if (ctrl.emit) begin
					pend_v_q <= 1'b1;
					cnt_q    <= cnt_q + 1'b1;
				end else if (ctrl.finish) begin
					pend_v_q <= 1'b0;
				end
			end
			if (push && !stall) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q   <= node_id;
			n_q   <= n_sat;
			m_q   <= m_new;
			bad_q <= bad_new;
		end
		if (ctrl.emit && !stall) begin
			pend_peer_q <= cand_peer;
			pend_recv_q <= ctrl.recv;
			pend_js_q   <= ctrl.js;
			pend_red_q  <= ctrl.red;
			pend_bad_q  <= ctrl.bad;
		end
		if (push && !stall) begin
			out_peer_q <= pend_peer_q;
			out_recv_q <= pend_recv_q;
			out_js_q   <= pend_js_q;
			out_red_q  <= pend_red_q;
			out_bad_q  <= pend_bad_q;
			out_last_q <= ctrl.finish;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.peer_id     = out_peer_q;
	assign rsp.receive     = out_recv_q;
	assign rsp.jumpstart   = out_js_q;
	assign rsp.reduce      = out_red_q;
	assign rsp.bad_request = out_bad_q;
	assign rsp.last        = out_last_q;

	`RSG_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(LIMIT), "action count passed the limit")
	`RSG_ASSERT_IMP(a_bad_is_last, rsp.valid && rsp.bad_request, rsp.last, "flagged action not last")

endmodule

// ----- rtl/reduction_schedule_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reduction schedule generator
// Turns one node number into that node's ordered list of reduction actions
// for the configured pattern (star, all-to-all or butterfly) and node count.
//
//   Channel   Direction  Payload
//   req       in         node_id
//   rsp       out        peer_id, receive, jumpstart, reduce, bad_request, last
//   cfg       in         cfg_index 0 pattern, 1 node_count (write only)
//
// A request runs one microcode step per cycle unless the action channel stalls.
// The next request is taken once the previous list has been fully issued.
// A stalled action channel freezes the sequencer; one action is held back so
// the final one can carry last. Reset restores pattern butterfly, count 32.
// ----------------------------------------------------------------------------
module reduction_schedule_generator #(
	parameter int MAX_NODES   = rsg_pkg::RSG_MAX_NODES,
	parameter int MAX_ACTIONS = rsg_pkg::RSG_MAX_ACTIONS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsg_pkg::CFG_DATA_W-1:0] cfg_data,
	rsg_req_if.sink                        req,
	rsg_rsp_if.source                      rsp
);
	import rsg_pkg::*;

	rsg_ctrl_t ctrl;
	rsg_stat_t stat;
	logic      busy;
	logic      start;

	assign req.ready = !busy;
	assign start     = req.valid && !busy;

	rsg_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	rsg_dpath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_ACTIONS (MAX_ACTIONS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.node_id   (req.node_id),
		.ctrl      (ctrl),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule
